// ----- src/cht_pkg.sv -----
package cht_pkg;

	localparam int NODE_POOL   = 256;
	localparam int MAX_BUCKETS = 256;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int NODE_W      = $clog2(NODE_POOL);
	localparam int LINK_W      = NODE_W + 1;
	localparam int BKT_W       = $clog2(MAX_BUCKETS);
	localparam int CNT_W       = $clog2(NODE_POOL + 1);
	localparam int CFG_W       = 9;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_PUT    = 2'd0;
	localparam func_t FUNC_GET    = 2'd1;
	localparam func_t FUNC_REMOVE = 2'd2;
	localparam func_t FUNC_EXISTS = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_MISSING = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	localparam logic [LINK_W-1:0] NIL_NODE = LINK_W'(NODE_POOL);

endpackage

// ----- src/chained_hash_table.sv -----
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid / cfg_ready     bucket_count (9 bits)
// s_axis    in         s_axis_tvalid / tready    func, key, value
// m_axis    out        m_axis_tvalid / tready    status, read_value, entry_count
//
// One request at a time. The modulo is a shift and subtract loop over the key
// bits, then S_HEAD, S_HEADW and S_NODE fetch the bucket head, and the walk
// passes S_NODEW and S_DECIDE for each chain node, one more S_DECIDE on a hit.
// A new put then goes through the update states S_POPW and S_LINK, and a
// remove through S_REMW, before the result is shown.
// After reset a clearing pass writes every bucket head and free stack entry,
// one per cycle, during which no request is taken.
// The result waits in an output register; a stalled output holds the block.
module chained_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// s_axis_tdata: key [31:0], value [63:32]
	input  logic [63:0] s_axis_tdata,
	// s_axis_tuser: func [1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// m_axis_tdata: read_value [31:0], entry_count [40:32], zeros [47:41]
	output logic [47:0] m_axis_tdata,
	// m_axis_tuser: status [1:0]
	output logic [1:0]  m_axis_tuser
);

	localparam int NW = cht_pkg::NODE_W;
	localparam int LW = cht_pkg::LINK_W;
	localparam int BW = cht_pkg::BKT_W;
	localparam int CW = cht_pkg::CNT_W;
	localparam int KW = cht_pkg::KEY_BITS;
	localparam int VW = cht_pkg::VALUE_BITS;
	localparam int KC_W = $clog2(KW + 1);
	localparam int SC_W = $clog2(cht_pkg::NODE_POOL + 1);
	localparam int CLR_N = (cht_pkg::NODE_POOL > cht_pkg::MAX_BUCKETS) ?
		cht_pkg::NODE_POOL : cht_pkg::MAX_BUCKETS;
	localparam int CLR_W = $clog2(CLR_N);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_HEADW, S_NODE, S_NODEW, S_DECIDE,
		S_POPW, S_LINK, S_REMW, S_OUT
	} state_t;

	// Memories, each written at one address and read at one address.
	logic [LW-1:0] head_mem [cht_pkg::MAX_BUCKETS];
	logic [KW-1:0] key_mem  [cht_pkg::NODE_POOL];
	logic [VW-1:0] data_mem [cht_pkg::NODE_POOL];
	logic [LW-1:0] link_mem [cht_pkg::NODE_POOL];
	logic [NW-1:0] free_mem [cht_pkg::NODE_POOL];

	state_t            state_q;
	logic [8:0]        bcount_q;
	logic [CW-1:0]     free_top_q, stored_q;
	logic [CLR_W:0]    clr_q;
	cht_pkg::func_t    func_q;
	logic [KW-1:0]     key_q, rem_key_q;
	logic [VW-1:0]     val_q;
	logic [8:0]        rem_q, div_q;
	logic [KC_W-1:0]   kcnt_q;
	logic [BW-1:0]     bkt_q;
	logic [LW-1:0]     cur_q, prev_q;
	logic [SC_W-1:0]   steps_q;
	logic              hit_q;
	logic [LW-1:0]     hit_link_q;
	logic [NW-1:0]     new_node_q;
	cht_pkg::status_t  res_status_q;
	logic [VW-1:0]     res_data_q;
	logic [CW-1:0]     res_cnt_q;

	// Registered memory read ports.
	logic [LW-1:0] head_rd_q, link_rd_q;
	logic [KW-1:0] key_rd_q;
	logic [VW-1:0] data_rd_q;
	logic [NW-1:0] free_rd_q;

	// Write port controls.
	logic          head_we, key_we, data_we, link_we, free_we;
	logic [BW-1:0] head_wa;
	logic [NW-1:0] node_wa, link_wa, free_wa;
	logic [LW-1:0] head_wd, link_wd;
	logic [VW-1:0] data_wd;
	logic [NW-1:0] free_wd;
	logic [NW-1:0] node_ra;
	logic [NW-1:0] free_ra;

	logic [9:0]    rem_sh;
	logic          cur_valid;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tdata  = {7'd0, res_cnt_q, res_data_q};
	assign m_axis_tuser  = res_status_q;
	assign rem_sh        = {rem_q, key_q[KW-1]};
	assign cur_valid     = (cur_q < cht_pkg::NIL_NODE) &&
		(steps_q < SC_W'(cht_pkg::NODE_POOL));
	assign node_ra       = cur_q[NW-1:0];
	assign free_ra       = NW'(free_top_q - CW'(1));

	// Memory ports.
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		if (key_we) key_mem[node_wa] <= key_q;
		if (data_we) data_mem[node_wa] <= data_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (free_we) free_mem[free_wa] <= free_wd;
		head_rd_q <= head_mem[bkt_q];
		key_rd_q  <= key_mem[node_ra];
		data_rd_q <= data_mem[node_ra];
		link_rd_q <= link_mem[node_ra];
		free_rd_q <= free_mem[free_ra];
	end

	// Write decode for the clearing pass and the update states.
	always_comb begin
		head_we = 1'b0; key_we = 1'b0; data_we = 1'b0; link_we = 1'b0;
		free_we = 1'b0;
		head_wa = bkt_q; head_wd = cht_pkg::NIL_NODE;
		node_wa = free_rd_q; data_wd = val_q;
		link_wa = free_rd_q; link_wd = cht_pkg::NIL_NODE;
		free_wa = NW'(free_top_q); free_wd = cur_q[NW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				head_we = (clr_q < (CLR_W+1)'(cht_pkg::MAX_BUCKETS));
				head_wa = clr_q[BW-1:0];
				free_we = (clr_q < (CLR_W+1)'(cht_pkg::NODE_POOL));
				free_wa = clr_q[NW-1:0];
				free_wd = NW'(cht_pkg::NODE_POOL - 1) - clr_q[NW-1:0];
			end
			S_DECIDE: begin
				if (hit_q && func_q == cht_pkg::FUNC_PUT) begin
					data_we = 1'b1;
					node_wa = cur_q[NW-1:0];
				end
			end
			// The popped node gets its key, value and an empty link.
			S_POPW: begin
				key_we = 1'b1; data_we = 1'b1; link_we = 1'b1;
			end
			// Hang the new node behind the tail, or at the head of an empty chain.
			S_LINK: begin
				if (prev_q < cht_pkg::NIL_NODE) begin
					link_we = 1'b1; link_wa = prev_q[NW-1:0]; link_wd = LW'(new_node_q);
				end else begin
					head_we = 1'b1; head_wd = LW'(new_node_q);
				end
			end
			S_REMW: begin
				if (prev_q < cht_pkg::NIL_NODE) begin
					link_we = 1'b1; link_wa = prev_q[NW-1:0]; link_wd = hit_link_q;
				end else begin
					head_we = 1'b1; head_wd = hit_link_q;
				end
				free_we = (free_top_q < CW'(cht_pkg::NODE_POOL));
			end
			default: ;
		endcase
	end

	// Control state machine and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			bcount_q      <= 9'(cht_pkg::MAX_BUCKETS < 256 ? cht_pkg::MAX_BUCKETS : 256);
			free_top_q    <= CW'(cht_pkg::NODE_POOL);
			stored_q      <= '0;
			clr_q         <= '0;
			m_axis_tvalid <= 1'b0;
			func_q        <= cht_pkg::FUNC_PUT;
			key_q         <= '0;
			rem_key_q     <= '0;
			val_q         <= '0;
			rem_q         <= '0;
			div_q         <= 9'd1;
			kcnt_q        <= '0;
			bkt_q         <= '0;
			cur_q         <= cht_pkg::NIL_NODE;
			prev_q        <= cht_pkg::NIL_NODE;
			steps_q       <= '0;
			hit_q         <= 1'b0;
			hit_link_q    <= cht_pkg::NIL_NODE;
			new_node_q    <= '0;
			res_status_q  <= cht_pkg::ST_OK;
			res_data_q    <= '0;
			res_cnt_q     <= '0;
		end else begin
			if (cfg_valid) bcount_q <= cfg_data;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + (CLR_W+1)'(1);
					if (clr_q == (CLR_W+1)'(CLR_N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						func_q    <= s_axis_tuser;
						key_q     <= s_axis_tdata[KW-1:0];
						rem_key_q <= s_axis_tdata[KW-1:0];
						val_q     <= s_axis_tdata[KW+VW-1:KW];
						rem_q     <= '0;
						kcnt_q    <= '0;
						if (bcount_q == 9'd0) div_q <= 9'd1;
						else if (bcount_q > 9'(cht_pkg::MAX_BUCKETS))
							div_q <= 9'(cht_pkg::MAX_BUCKETS);
						else div_q <= bcount_q;
						state_q <= S_MOD;
					end
				end
				// Restoring remainder, one key bit per cycle.
				S_MOD: begin
					key_q <= key_q << 1;
					if (rem_sh >= {1'b0, div_q}) rem_q <= 9'(rem_sh - {1'b0, div_q});
					else rem_q <= rem_sh[8:0];
					kcnt_q <= kcnt_q + KC_W'(1);
					if (kcnt_q == KC_W'(KW - 1)) state_q <= S_HEAD;
				end
				S_HEAD: begin
					key_q   <= rem_key_q;
					bkt_q   <= BW'(rem_q);
					state_q <= S_HEADW;
				end
				S_HEADW: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					cur_q   <= head_rd_q;
					prev_q  <= cht_pkg::NIL_NODE;
					steps_q <= '0;
					hit_q   <= 1'b0;
					state_q <= S_NODEW;
				end
				// The node memories are read at cur_q during this cycle.
				S_NODEW: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// Memory outputs hold the node at cur_q here.
					if (cur_valid && !hit_q) begin
						if (key_rd_q == key_q) begin
							hit_q      <= 1'b1;
							hit_link_q <= link_rd_q;
						end else begin
							prev_q  <= cur_q;
							cur_q   <= link_rd_q;
							steps_q <= steps_q + SC_W'(1);
							state_q <= S_NODEW;
						end
					end else begin
						res_cnt_q  <= stored_q;
						res_data_q <= (hit_q && func_q == cht_pkg::FUNC_GET) ? data_rd_q : '0;
						if (hit_q) begin
							res_status_q <= cht_pkg::ST_OK;
							if (func_q == cht_pkg::FUNC_REMOVE) begin
								state_q <= S_REMW;
							end else begin
								state_q       <= S_OUT;
								m_axis_tvalid <= 1'b1;
							end
						end else if (func_q != cht_pkg::FUNC_PUT) begin
							res_status_q  <= cht_pkg::ST_MISSING;
							state_q       <= S_OUT;
							m_axis_tvalid <= 1'b1;
						end else if (free_top_q == '0) begin
							res_status_q  <= cht_pkg::ST_FULL;
							state_q       <= S_OUT;
							m_axis_tvalid <= 1'b1;
						end else begin
							res_status_q <= cht_pkg::ST_OK;
							state_q      <= S_POPW;
						end
					end
				end
				S_POPW: begin
					free_top_q <= free_top_q - CW'(1);
					stored_q   <= stored_q + CW'(1);
					res_cnt_q  <= stored_q + CW'(1);
					new_node_q <= free_rd_q;
					state_q    <= S_LINK;
				end
				S_LINK: begin
					state_q       <= S_OUT;
					m_axis_tvalid <= 1'b1;
				end
				S_REMW: begin
					if (free_top_q < CW'(cht_pkg::NODE_POOL))
						free_top_q <= free_top_q + CW'(1);
					if (stored_q != '0) begin
						stored_q  <= stored_q - CW'(1);
						res_cnt_q <= stored_q - CW'(1);
					end
					state_q       <= S_OUT;
					m_axis_tvalid <= 1'b1;
				end
				S_OUT: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The result is only shown in the output state.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> state_q == S_OUT)
		else $error("result shown outside output state");
	// Stored entries never exceed the pool.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(cht_pkg::NODE_POOL))
		else $error("entry count overflow");
	// Free and stored nodes add up to the pool.
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (free_top_q + stored_q) == CW'(cht_pkg::NODE_POOL))
		else $error("pool accounting broken");

endmodule

// ----- bench/cht_checker.sv -----
`timescale 1ns / 100ps

// Watches the configuration, request and result channels of the hash table,
// keeps its own copy of the table and checks every result transfer in order.
module cht_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// s_axis_tdata: key [31:0], value [63:32]
	input  logic [63:0] s_axis_tdata,
	// s_axis_tuser: func [1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// m_axis_tdata: read_value [31:0], entry_count [40:32], zeros [47:41]
	input  logic [47:0] m_axis_tdata,
	// m_axis_tuser: status [1:0]
	input  logic [1:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending
);

	localparam int POOL    = cht_pkg::NODE_POOL;
	localparam int BUCKETS = cht_pkg::MAX_BUCKETS;

	typedef struct packed {
		cht_pkg::status_t status;
		logic [31:0]      read_value;
		logic [8:0]       entry_count;
	} table_reply_t;

	table_reply_t replies_due[$];

	// Shadow copy of the table.
	logic [8:0]  buckets_used;
	logic [8:0]  head_of[BUCKETS];
	logic [31:0] key_of[POOL];
	logic [31:0] data_of[POOL];
	logic [8:0]  next_of[POOL];
	logic [7:0]  free_list[POOL];
	logic [8:0]  free_level;
	logic [8:0]  entries;

	task automatic clear_table();
		buckets_used = 9'd256;
		for (int i = 0; i < BUCKETS; i++) head_of[i] = cht_pkg::NIL_NODE;
		for (int i = 0; i < POOL; i++) begin
			key_of[i]    = '0;
			data_of[i]   = '0;
			next_of[i]   = cht_pkg::NIL_NODE;
			free_list[i] = 8'(POOL - 1 - i);
		end
		free_level = 9'(POOL);
		entries    = '0;
	endtask

	// Applies one request to the shadow table and returns its reply.
	function automatic table_reply_t apply_request(cht_pkg::func_t f, logic [31:0] k,
			logic [31:0] v);
		table_reply_t r;
		int n, b, cur, last, hit, prev, steps, fresh;
		r.status     = cht_pkg::ST_OK;
		r.read_value = '0;
		n = buckets_used;
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		b = k % n;
		// Walk the chain; last ends up at the node ahead of the hit or at the tail, prev ahead of the hit.
		cur   = head_of[b];
		last  = POOL;
		hit   = POOL;
		prev  = POOL;
		steps = 0;
		while (cur < POOL && steps < POOL) begin
			if (key_of[cur] == k) begin
				hit  = cur;
				prev = last;
				break;
			end
			last = cur;
			cur  = next_of[cur];
			steps++;
		end
		if (f == cht_pkg::FUNC_PUT) begin
			if (hit < POOL) begin
				data_of[hit] = v;
			end else if (free_level == 0) begin
				r.status = cht_pkg::ST_FULL;
			end else begin
				free_level--;
				fresh          = free_list[free_level];
				key_of[fresh]  = k;
				data_of[fresh] = v;
				next_of[fresh] = cht_pkg::NIL_NODE;
				if (last < POOL) next_of[last] = 9'(fresh);
				else head_of[b] = 9'(fresh);
				entries++;
			end
		end else if (hit >= POOL) begin
			r.status = cht_pkg::ST_MISSING;
		end else if (f == cht_pkg::FUNC_GET) begin
			r.read_value = data_of[hit];
		end else if (f == cht_pkg::FUNC_REMOVE) begin
			if (prev < POOL) next_of[prev] = next_of[hit];
			else head_of[b] = next_of[hit];
			next_of[hit] = cht_pkg::NIL_NODE;
			if (free_level < POOL) begin
				free_list[free_level] = 8'(hit);
				free_level++;
			end
			if (entries > 0) entries--;
		end
		r.entry_count = entries;
		return r;
	endfunction

	// Compare result transfers first, then take configuration and request transfers.
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			clear_table();
			replies_due.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: result transfer with nothing expected: status %0d data %h",
						$time, m_axis_tuser, m_axis_tdata);
					errs++;
				end else begin
					want = replies_due.pop_front();
					if (m_axis_tuser !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, m_axis_tuser);
						errs++;
					end
					if (m_axis_tdata[31:0] !== want.read_value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, m_axis_tdata[31:0]);
						errs++;
					end
					if (m_axis_tdata[40:32] !== want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, m_axis_tdata[40:32]);
						errs++;
					end
					if (m_axis_tdata[47:41] !== 7'd0) begin
						$display("%0t: pad bits expected 0 actual %h",
							$time, m_axis_tdata[47:41]);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) buckets_used = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				replies_due.push_back(apply_request(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
			fail_count <= fail_count + errs;
			pending    <= replies_due.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	int          fail_count;
	int          pending;
	logic        quiet = 1'b0;
	int          sink_hold = 0;
	int          idle_cycles = 0;
	int          cur_buckets = 256;

	always #2 clk = ~clk;

	chained_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	cht_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	// Result side: after each transfer, stall a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_hold     <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			r = quiet ? 0 : $urandom_range(0, 7);
			sink_hold     <= r;
			m_axis_tready <= (r == 0);
		end else if (sink_hold > 0) begin
			sink_hold     <= sink_hold - 1;
			m_axis_tready <= (sink_hold == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// One request transfer, preceded by a random gap.
	task automatic send_req(cht_pkg::func_t f, logic [31:0] k, logic [31:0] v);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= f;
		s_axis_tdata  <= {v, k};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	// Hold the sender until every expected result has come.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_buckets(logic [8:0] bc);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= bc;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cur_buckets = (bc == 0) ? 1 : (bc > cht_pkg::MAX_BUCKETS) ? cht_pkg::MAX_BUCKETS : bc;
	endtask

	// Random requests over a small key set so that keys collide and recur.
	task automatic random_phase(int n_items);
		logic [31:0]    keys[24];
		logic [31:0]    k;
		int             op;
		cht_pkg::func_t f;
		for (int j = 0; j < 24; j++) begin
			case (j % 3)
				0: keys[j] = $urandom;
				1: keys[j] = $urandom_range(0, 600);
				default: keys[j] = keys[0] + 32'(j * cur_buckets);
			endcase
		end
		for (int i = 0; i < n_items; i++) begin
			if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) == 0) drain();
			k  = ($urandom_range(0, 9) == 0) ? $urandom : keys[$urandom_range(0, 23)];
			op = $urandom_range(0, 9);
			f  = (op < 4) ? cht_pkg::FUNC_PUT : (op < 6) ? cht_pkg::FUNC_GET :
				(op < 8) ? cht_pkg::FUNC_REMOVE : cht_pkg::FUNC_EXISTS;
			send_req(f, k, $urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: head and tail of a chain, replace, missing keys, extreme values.
		send_req(cht_pkg::FUNC_GET, 32'h0, 32'hFFFF_FFFF);
		send_req(cht_pkg::FUNC_PUT, 32'h0, 32'h0);
		send_req(cht_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(cht_pkg::FUNC_PUT, 32'd256, 32'hA5A5_5A5A);
		send_req(cht_pkg::FUNC_GET, 32'd256, 32'h0);
		send_req(cht_pkg::FUNC_EXISTS, 32'h0, 32'h0);
		send_req(cht_pkg::FUNC_PUT, 32'h0, 32'h1234_5678);
		send_req(cht_pkg::FUNC_GET, 32'h0, 32'h0);
		send_req(cht_pkg::FUNC_REMOVE, 32'h0, 32'h0);
		send_req(cht_pkg::FUNC_GET, 32'd256, 32'h0);
		send_req(cht_pkg::FUNC_REMOVE, 32'd256, 32'h0);
		send_req(cht_pkg::FUNC_REMOVE, 32'd256, 32'h0);
		send_req(cht_pkg::FUNC_EXISTS, 32'hFFFF_FFFF, 32'h0);
		send_req(cht_pkg::FUNC_EXISTS, 32'h7, 32'h0);
		send_req(cht_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_req(cht_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);

		// Fill the pool, overflow it, replace while full, then empty it again.
		for (int i = 0; i < 260; i++) send_req(cht_pkg::FUNC_PUT, 32'(1000 + i), $urandom);
		send_req(cht_pkg::FUNC_PUT, 32'd1000, 32'hDEAD_BEEF);
		send_req(cht_pkg::FUNC_GET, 32'd1000, 32'h0);
		for (int i = 0; i < 260; i++) send_req(cht_pkg::FUNC_REMOVE, 32'(1000 + i), 32'h0);

		random_phase(250);
		set_buckets(9'd1);
		random_phase(200);
		set_buckets(9'd7);
		random_phase(200);
		// Entries stay where they were put when the bucket count changes.
		set_buckets(9'd13);
		random_phase(200);
		set_buckets(9'd0);
		random_phase(150);
		set_buckets(9'd511);
		random_phase(150);
		set_buckets(9'd256);
		random_phase(100);
		set_buckets(9'd300);
		random_phase(100);

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
